// ----- rtl/base64_stream_decoder_unit_macros.svh -----
// Assertion macros for the Base64 stream decoder.
// Included by the top level; expects clk and rst in scope.
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define B64SD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64sd assertion failed");

// condition implies consequence in the next cycle
`define B64SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64sd assertion failed");

`endif

// ----- rtl/b64sd_pkg.sv -----
// Shared types and the character map for the Base64 stream decoder.
// No dependencies.
package b64sd_pkg;

  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_MARK  = 2'd1,
    FIN_BYTES = 2'd2
  } fin_t;

  // one input item's worth of results, handed to the serialiser
  typedef struct packed {
    logic        pre;
    logic [23:0] pre_triple;
    fin_t        fin;
    logic        fin_status;
    logic [1:0]  fin_count;
    logic [23:0] fin_triple;
  } job_t;

  typedef struct packed {
    logic stage_valid;
    logic job_valid;
  } core_status_t;

  localparam logic [7:0] CH_PAD = 8'h3D;

  function automatic logic is_blank(input logic [7:0] c);
    logic b;
    b = (c inside {8'h0A, 8'h0D, 8'h20, 8'h09});
    return b;
  endfunction

  // NUL maps to 64 so that it carries into the sextet above
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else if (c == 8'h00) begin
      d = 8'd64;
    end
    return d[6:0];
  endfunction

endpackage

// ----- rtl/b64sd_in_if.sv -----
// Character channel of the Base64 stream decoder.
// No dependencies.
interface b64sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, text_char, end_of_text, input ready);
  modport sink   (input valid, text_char, end_of_text, output ready);
endinterface

// ----- rtl/b64sd_out_if.sv -----
// Result channel of the Base64 stream decoder.
// No dependencies.
interface b64sd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       run_end;
  logic       status;

  modport source (output valid, data_byte, byte_valid, run_end, status, input ready);
  modport sink   (input valid, data_byte, byte_valid, run_end, status, output ready);
endinterface

// ----- rtl/b64sd_core.sv -----
// Input register and quartet state of the Base64 stream decoder.
// Depends on b64sd_pkg and b64sd_in_if.
module b64sd_core (
  input  logic                 clk,
  input  logic                 rst,
  b64sd_in_if.sink             text_in,
  output b64sd_pkg::job_t      job,
  output logic                 job_valid,
  input  logic                 job_take,
  output b64sd_pkg::core_status_t st
);

  logic        iv;
  logic [7:0]  ich;
  logic        iend;

  logic [23:0] sum, sum_next;
  logic [1:0]  pos, pos_next;
  logic [23:0] held, held_next;
  logic        hv, hv_next;
  logic        lwp, lwp_next;
  logic        slp, slp_next;

  logic        blank;
  logic [6:0]  sext;
  logic [23:0] shifted;
  logic        need;
  logic        consume;

  always_comb begin
    blank     = b64sd_pkg::is_blank(ich);
    sext      = b64sd_pkg::sextet_of(ich);
    shifted   = {sum[17:0], 6'd0} + {17'd0, sext};
    sum_next  = sum;
    pos_next  = pos;
    held_next = held;
    hv_next   = hv;
    lwp_next  = lwp;
    slp_next  = slp;
    job       = '0;
    job.fin   = b64sd_pkg::FIN_NONE;

    if (!blank) begin
      job.pre        = hv;
      job.pre_triple = held;
      hv_next        = 1'b0;
      sum_next       = shifted;
      slp_next       = lwp;
      lwp_next       = (ich == b64sd_pkg::CH_PAD);
      pos_next       = pos + 2'd1;
      if (pos_next == 2'd0) begin
        held_next = shifted;
        hv_next   = 1'b1;
        sum_next  = '0;
      end
    end

    if (iend) begin
      if (pos_next != 2'd0) begin
        job.fin        = b64sd_pkg::FIN_MARK;
        job.fin_status = 1'b1;
      end else if (hv_next) begin
        job.fin        = b64sd_pkg::FIN_BYTES;
        job.fin_triple = held_next;
        job.fin_count  = 2'd3 - {1'b0, lwp_next} - {1'b0, slp_next};
      end else begin
        job.fin = b64sd_pkg::FIN_MARK;
      end
    end

    need      = job.pre | iend;
    job_valid = iv & need;
    consume   = iv & (~need | job_take);
    text_in.ready   = ~iv | consume;
    st.stage_valid  = iv;
    st.job_valid    = job_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv   <= 1'b0;
      sum  <= '0;
      pos  <= '0;
      held <= '0;
      hv   <= 1'b0;
      lwp  <= 1'b0;
      slp  <= 1'b0;
    end else begin
      if (consume) begin
        if (iend) begin
          // end of text: back to the reset state
          sum  <= '0;
          pos  <= '0;
          held <= '0;
          hv   <= 1'b0;
          lwp  <= 1'b0;
          slp  <= 1'b0;
        end else begin
          sum  <= sum_next;
          pos  <= pos_next;
          held <= held_next;
          hv   <= hv_next;
          lwp  <= lwp_next;
          slp  <= slp_next;
        end
      end
      if (text_in.ready) begin
        iv <= text_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      ich  <= text_in.text_char;
      iend <= text_in.end_of_text;
    end
  end

endmodule

// ----- rtl/b64sd_ser.sv -----
// Serialiser: plays out a job's bytes and any end marker, one per ready cycle.
// Depends on b64sd_pkg and b64sd_out_if.
module b64sd_ser (
  input  logic            clk,
  input  logic            rst,
  input  b64sd_pkg::job_t job,
  input  logic            job_valid,
  output logic            job_take,
  b64sd_out_if.source     byte_out
);

  logic            busy;
  logic [2:0]      idx, idx_next;
  b64sd_pkg::job_t cur;

  logic            last;
  logic            xfer;
  logic [23:0]     triple;
  logic [1:0]      k;
  logic [2:0]      fin_last;

  always_comb begin
    fin_last = 3'd2 + {1'b0, cur.fin_count};
    case (cur.fin)
      b64sd_pkg::FIN_NONE:  last = (idx == 3'd2);
      b64sd_pkg::FIN_MARK:  last = (idx == 3'd3);
      b64sd_pkg::FIN_BYTES: last = (idx == fin_last);
      default:              last = 1'b1;
    endcase

    if (idx < 3'd3) begin
      triple = cur.pre_triple;
      k      = idx[1:0];
    end else begin
      triple = cur.fin_triple;
      k      = 2'(idx - 3'd3);
    end

    byte_out.valid = busy;
    byte_out.data_byte  = 8'd0;
    byte_out.byte_valid = 1'b1;
    byte_out.run_end    = 1'b0;
    byte_out.status     = 1'b0;
    if (idx >= 3'd3 && cur.fin == b64sd_pkg::FIN_MARK) begin
      byte_out.byte_valid = 1'b0;
      byte_out.run_end    = 1'b1;
      byte_out.status     = cur.fin_status;
    end else begin
      case (k)
        2'd0:    byte_out.data_byte = triple[23:16];
        2'd1:    byte_out.data_byte = triple[15:8];
        default: byte_out.data_byte = triple[7:0];
      endcase
      byte_out.run_end = (idx >= 3'd3) && last;
    end

    xfer     = busy & byte_out.ready;
    job_take = ~busy | (xfer & last);

    if (idx == 3'd2 && cur.fin == b64sd_pkg::FIN_NONE) begin
      idx_next = idx;
    end else begin
      idx_next = idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_take) begin
      busy <= job_valid;
      idx  <= job.pre ? 3'd0 : 3'd3;
    end else if (xfer) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job_valid) begin
      cur <= job;
    end
  end

endmodule

// ----- rtl/base64_stream_decoder_unit.sv -----
// Top level of the Base64 stream decoder: character stage plus serialiser.
// Depends on b64sd_pkg, b64sd_in_if, b64sd_out_if, b64sd_core, b64sd_ser
// and base64_stream_decoder_unit_macros.svh.
//
// Takes one character a cycle while the serialiser keeps up. Blanks, and
// characters that neither release a held quartet nor end the text, give no
// result. A character that releases a held quartet, or ends the text, hands
// a job of up to four results to the serialiser, which puts out one result
// per cycle while the result side is ready. The job is registered in the
// serialiser from the input register, where the next such character waits
// until the serialiser reaches the last result of its current job, so
// sustained rate is one character a cycle, limited by the single result port
// to three decoded bytes every four characters. A count error or empty text
// ends with one result carrying byte_valid low and run_end high.
`include "base64_stream_decoder_unit_macros.svh"

module base64_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  b64sd_in_if.sink    text_in,
  b64sd_out_if.source byte_out
);

  b64sd_pkg::job_t         job;
  logic                    job_valid;
  logic                    job_take;
  b64sd_pkg::core_status_t st;

  b64sd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .st        (st)
  );

  b64sd_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .byte_out  (byte_out)
  );

  // a stalled input means a character is parked waiting on the serialiser
  `B64SD_ASSERT_NOW(a_stall_has_job, !text_in.ready, st.stage_valid && st.job_valid && byte_out.valid)
  `B64SD_ASSERT_NOW(a_marker_ends_run, byte_out.valid && !byte_out.byte_valid, byte_out.run_end && byte_out.data_byte == 8'd0)
  `B64SD_ASSERT_NOW(a_error_is_marker, byte_out.valid && byte_out.status, byte_out.run_end && !byte_out.byte_valid)
  `B64SD_ASSERT_NEXT(a_job_starts_output, job_valid && job_take, byte_out.valid)

endmodule
